[sv/sync_frame_receiver_fletcher16_defines.svh]
// ----------------------------------------------------------------------------
// Sync frame receiver assertion macros
// Concurrent assertion helpers shared by the receiver RTL. They expand to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAME_RECEIVER_FLETCHER16_DEFINES_SVH
`define SYNC_FRAME_RECEIVER_FLETCHER16_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define SFRF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);
// Condition in one cycle that requires another in the next cycle.
`define SFRF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFRF_ASSERT(lbl, clk, rstn, prop, msg)
`define SFRF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[sv/sfrf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync frame receiver package
// Phase and status codes, header layout constants and shared structs.
// ----------------------------------------------------------------------------
package sfrf_pkg;

  typedef enum logic [1:0] {
    PH_WAIT_D,
    PH_WAIT_F,
    PH_HEADER,
    PH_PAYLOAD
  } phase_e;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_GOOD     = 3'd1,
    ST_BADSUM   = 3'd2,
    ST_TOOLONG  = 3'd3,
    ST_SYNCLOST = 3'd4
  } status_e;

  localparam logic [7:0]  SYNC_0      = 8'h44;
  localparam logic [7:0]  SYNC_1      = 8'h46;
  localparam logic [8:0]  MOD255      = 9'd255;

  localparam logic [15:0] ID_OFS      = 16'd2;
  localparam logic [15:0] TYPE_OFS    = 16'd6;
  localparam logic [15:0] LEN_OFS     = 16'd8;
  localparam logic [15:0] HDR_LEN     = 16'd10;
  localparam logic [15:0] CHECK_LEN   = 16'd2;
  localparam logic [15:0] MAX_LEN_RST = 16'd256;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic [15:0] byte_position;
    logic        frame_end;
    status_e     frame_status;
    logic [31:0] frame_id;
    logic [15:0] frame_type;
  } result_t;

  typedef struct packed {
    logic update;
    logic restart;
    logic clear;
  } sum_ctl_t;

endpackage

[sv/sfrf_fletcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fletcher-16 accumulator
// Holds both running sums modulo 255 and presents their updated values.
// ----------------------------------------------------------------------------
module sfrf_fletcher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfrf_pkg::sum_ctl_t ctl_i,
  input  logic [7:0]         data_i,
  output logic [7:0]         low_o,
  output logic [7:0]         high_o
);

  logic [7:0] low_q, high_q;
  logic [7:0] low_base, high_base;
  logic [8:0] low_sum, high_sum;

  // The stored sums stay below 255, so one conditional subtract reduces the sum.
  always_comb begin
    low_base  = ctl_i.restart ? 8'd0 : low_q;
    high_base = ctl_i.restart ? 8'd0 : high_q;
    low_sum   = {1'b0, low_base} + {1'b0, data_i};
    low_o     = (low_sum >= sfrf_pkg::MOD255) ? 8'(low_sum - sfrf_pkg::MOD255)
                                              : low_sum[7:0];
    high_sum  = {1'b0, high_base} + {1'b0, low_o};
    high_o    = (high_sum >= sfrf_pkg::MOD255) ? 8'(high_sum - sfrf_pkg::MOD255)
                                               : high_sum[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= 8'd0;
      high_q <= 8'd0;
    end else if (ctl_i.clear) begin
      low_q  <= 8'd0;
      high_q <= 8'd0;
    end else if (ctl_i.update) begin
      low_q  <= low_o;
      high_q <= high_o;
    end
  end

endmodule

[sv/sfrf_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync frame receiver core
// Sync hunt, header capture, length check and frame end detection for one
// word per cycle whenever go_i is high.
// ----------------------------------------------------------------------------
module sfrf_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  logic [7:0]        data_i,
  input  logic [15:0]       max_len_i,
  output logic              emit_o,
  output sfrf_pkg::result_t res_o
);

  sfrf_pkg::phase_e   phase_q, phase_d;
  sfrf_pkg::sum_ctl_t sum_ctl;
  logic [15:0] count_q, count_d;
  logic [15:0] total_q, total_d;
  logic [31:0] id_q, id_d;
  logic [15:0] type_q, type_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [7:0]  low_new, high_new;
  logic [15:0] cnt_inc;
  logic [16:0] total_new;
  logic        too_long;
  logic        hdr_last;
  logic        pay_done;
  logic [1:0]  id_sel;

  sfrf_fletcher u_fletcher (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sum_ctl),
    .data_i (data_i),
    .low_o  (low_new),
    .high_o (high_new)
  );

  assign cnt_inc   = count_q + 16'd1;
  assign total_new = 17'(sfrf_pkg::HDR_LEN) + 17'(sfrf_pkg::CHECK_LEN)
                   + {1'b0, data_i, len_lo_q};
  assign too_long  = total_new > {1'b0, max_len_i};
  assign hdr_last  = (count_q == sfrf_pkg::HDR_LEN - 16'd1);
  assign pay_done  = (cnt_inc >= total_q);
  assign id_sel    = 2'(count_q - sfrf_pkg::ID_OFS);

  always_comb begin
    phase_d = phase_q;
    if (go_i) begin
      case (phase_q)
        sfrf_pkg::PH_WAIT_D: begin
          if (data_i == sfrf_pkg::SYNC_0) phase_d = sfrf_pkg::PH_WAIT_F;
        end
        sfrf_pkg::PH_WAIT_F: begin
          if (data_i == sfrf_pkg::SYNC_1) begin
            phase_d = sfrf_pkg::PH_HEADER;
          end else if (data_i != sfrf_pkg::SYNC_0) begin
            phase_d = sfrf_pkg::PH_WAIT_D;
          end
        end
        sfrf_pkg::PH_HEADER: begin
          if (hdr_last) phase_d = too_long ? sfrf_pkg::PH_WAIT_D : sfrf_pkg::PH_PAYLOAD;
        end
        sfrf_pkg::PH_PAYLOAD: begin
          if (pay_done) phase_d = sfrf_pkg::PH_WAIT_D;
        end
        default: phase_d = sfrf_pkg::PH_WAIT_D;
      endcase
    end
  end

  always_comb begin
    emit_o              = 1'b0;
    res_o.frame_byte    = data_i;
    res_o.byte_position = count_q;
    res_o.frame_end     = 1'b0;
    res_o.frame_status  = sfrf_pkg::ST_BUSY;
    res_o.frame_id      = 32'd0;
    res_o.frame_type    = 16'd0;
    sum_ctl             = '0;
    count_d             = count_q;
    total_d             = total_q;
    id_d                = id_q;
    type_d              = type_q;
    len_lo_d            = len_lo_q;
    if (go_i) begin
      case (phase_q)
        sfrf_pkg::PH_WAIT_D: begin
          if (data_i == sfrf_pkg::SYNC_0) begin
            emit_o              = 1'b1;
            res_o.byte_position = 16'd0;
            sum_ctl.restart     = 1'b1;
            sum_ctl.update      = 1'b1;
            count_d             = 16'd1;
          end
        end
        sfrf_pkg::PH_WAIT_F: begin
          res_o.byte_position = 16'd1;
          if (data_i == sfrf_pkg::SYNC_1) begin
            emit_o         = 1'b1;
            sum_ctl.update = 1'b1;
            count_d        = 16'd2;
          end else if (data_i != sfrf_pkg::SYNC_0) begin
            emit_o             = 1'b1;
            res_o.frame_end    = 1'b1;
            res_o.frame_status = sfrf_pkg::ST_SYNCLOST;
            sum_ctl.clear      = 1'b1;
            count_d            = 16'd0;
          end
        end
        sfrf_pkg::PH_HEADER: begin
          emit_o         = 1'b1;
          sum_ctl.update = 1'b1;
          count_d        = cnt_inc;
          if (count_q >= sfrf_pkg::ID_OFS && count_q < sfrf_pkg::TYPE_OFS) begin
            id_d[{id_sel, 3'b000} +: 8] = data_i;
          end else if (count_q == sfrf_pkg::TYPE_OFS) begin
            type_d[7:0] = data_i;
          end else if (count_q == sfrf_pkg::TYPE_OFS + 16'd1) begin
            type_d[15:8] = data_i;
          end else if (count_q == sfrf_pkg::LEN_OFS) begin
            len_lo_d = data_i;
          end
          if (hdr_last) begin
            if (too_long) begin
              res_o.frame_end    = 1'b1;
              res_o.frame_status = sfrf_pkg::ST_TOOLONG;
              res_o.frame_id     = id_q;
              res_o.frame_type   = type_q;
              sum_ctl.clear      = 1'b1;
              count_d            = 16'd0;
            end else begin
              // Not too long means the total fits the 16-bit limit.
              total_d = total_new[15:0];
            end
          end
        end
        sfrf_pkg::PH_PAYLOAD: begin
          emit_o         = 1'b1;
          sum_ctl.update = 1'b1;
          count_d        = cnt_inc;
          if (pay_done) begin
            res_o.frame_end    = 1'b1;
            res_o.frame_status = (low_new == 8'd0 && high_new == 8'd0)
                               ? sfrf_pkg::ST_GOOD : sfrf_pkg::ST_BADSUM;
            res_o.frame_id     = id_q;
            res_o.frame_type   = type_q;
            sum_ctl.clear      = 1'b1;
            count_d            = 16'd0;
          end
        end
        default: begin
          count_d = 16'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= sfrf_pkg::PH_WAIT_D;
      count_q  <= 16'd0;
      total_q  <= 16'd0;
      id_q     <= 32'd0;
      type_q   <= 16'd0;
      len_lo_q <= 8'd0;
    end else begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      total_q  <= total_d;
      id_q     <= id_d;
      type_q   <= type_d;
      len_lo_q <= len_lo_d;
    end
  end

endmodule

[sv/sync_frame_receiver_fletcher16.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync frame receiver with Fletcher-16 check
// Hunts for the sync pair, parses the header and checks each frame.
// ----------------------------------------------------------------------------
// The input channel carries one received byte per word (in_valid_i, in_stall_o,
// rx_byte_i). The output channel carries one result word per stored frame byte
// (out_valid_o, out_stall_i and the frame fields). Bytes other than 'D' seen
// while hunting, and repeated 'D' bytes while waiting for 'F', give no word.
// An accepted byte sits in an input register, is processed there by the parser
// and the Fletcher-16 accumulator, and its result lands in the output register.
// Throughput is one word per cycle while out_stall_i is low, limited only by
// the single pass through the parser between those two registers.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more byte; in_stall_o rises only once both are full.
// Users write the max frame length register (cfg_we_i / cfg_wdata_i) only
// while the block is idle; the block does not enforce it. Reset returns the
// parser to the hunt, empties both registers and sets max frame length to 256.
// ----------------------------------------------------------------------------
`include "sync_frame_receiver_fletcher16_defines.svh"

module sync_frame_receiver_fletcher16 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic [15:0] byte_position_o,
  output logic        frame_end_o,
  output logic [2:0]  frame_status_o,
  output logic [31:0] frame_id_o,
  output logic [15:0] frame_type_o
);

  logic              s1_valid_q, s1_valid_d;
  logic [7:0]        s1_data_q;
  logic              out_valid_q, out_valid_d;
  sfrf_pkg::result_t out_res_q;
  sfrf_pkg::result_t core_res;
  logic              core_emit;
  logic [15:0]       max_len_q;
  logic              out_free;
  logic              s1_go;
  logic              in_accept;

  // The result register can take a new word when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;
  // The word in the input register is processed whenever the result register
  // can take whatever it may produce.
  assign s1_go      = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_free) out_valid_d = s1_go && core_emit;
  end

  sfrf_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (s1_go),
    .data_i    (s1_data_q),
    .max_len_i (max_len_q),
    .emit_o    (core_emit),
    .res_o     (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= sfrf_pkg::MAX_LEN_RST;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) max_len_q <= cfg_wdata_i;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset; their valid bits qualify them.
  always_ff @(posedge clk_i) begin
    if (in_accept) s1_data_q <= rx_byte_i;
    if (out_free && s1_go && core_emit) out_res_q <= core_res;
  end

  assign out_valid_o     = out_valid_q;
  assign frame_byte_o    = out_res_q.frame_byte;
  assign byte_position_o = out_res_q.byte_position;
  assign frame_end_o     = out_res_q.frame_end;
  assign frame_status_o  = 3'(out_res_q.frame_status);
  assign frame_id_o      = out_res_q.frame_id;
  assign frame_type_o    = out_res_q.frame_type;

  // A word ends its frame exactly when it carries a final status.
  `SFRF_ASSERT(a_end_matches_status, clk_i, rst_ni,
    !out_valid_o || (frame_end_o == (frame_status_o != 3'(sfrf_pkg::ST_BUSY))),
    "frame end flag disagrees with frame status")

  // Back-pressure reaches the input only when the input register is occupied.
  `SFRF_ASSERT(a_stall_needs_full, clk_i, rst_ni,
    !in_stall_o || s1_valid_q,
    "input stalled with an empty input register")

  // A lost sync always reports the second frame position and no header fields.
  `SFRF_ASSERT(a_sync_lost_fields, clk_i, rst_ni,
    !(out_valid_o && frame_status_o == 3'(sfrf_pkg::ST_SYNCLOST)) ||
    (byte_position_o == 16'd1 && frame_id_o == 32'd0 && frame_type_o == 16'd0),
    "sync lost word carries wrong position or header fields")

  // A processed byte that produces a word must show it in the next cycle.
  `SFRF_ASSERT_NEXT(a_emit_reaches_out, clk_i, rst_ni,
    s1_go && core_emit,
    out_valid_o,
    "emitted word did not reach the output register")

endmodule
